>>> rtl/core/rrsh_pkg.sv
// ----------------------------------------------------------------------------
// rrsh_pkg
// constants and tables shared by the rotated rectangle segment hit pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rrsh_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam int CORDIC_XW    = 18;
  localparam int CORDIC_ZW    = 33;
  localparam int TRIG_W       = 16;
  localparam int ROUND_BIAS   = 32768;
  localparam int ROUND_SHIFT  = 16;

  localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 18'sd19898;
  localparam logic signed [CORDIC_XW-1:0] TRIG_MAX  = 18'sd32767;
  localparam logic signed [CORDIC_XW-1:0] TRIG_MIN  = -18'sd32767;

  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;
  localparam quad_t QUAD_3 = 2'd3;

  // corner k: length sign negative / width sign negative
  localparam logic [3:0] LEN_NEG = 4'b1100;
  localparam logic [3:0] WID_NEG = 4'b1001;

  function automatic logic signed [CORDIC_ZW-1:0] atan_turn(input logic [3:0] idx);
    logic signed [CORDIC_ZW-1:0] v;
    case (idx)
      4'd0:  v = 33'sd536870912;
      4'd1:  v = 33'sd316933406;
      4'd2:  v = 33'sd167458907;
      4'd3:  v = 33'sd85004756;
      4'd4:  v = 33'sd42667331;
      4'd5:  v = 33'sd21354465;
      4'd6:  v = 33'sd10679838;
      4'd7:  v = 33'sd5340245;
      4'd8:  v = 33'sd2670163;
      4'd9:  v = 33'sd1335087;
      4'd10: v = 33'sd667544;
      4'd11: v = 33'sd333772;
      4'd12: v = 33'sd166886;
      4'd13: v = 33'sd83443;
      4'd14: v = 33'sd41722;
      4'd15: v = 33'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/rotated_rect_segment_hit.sv
// ----------------------------------------------------------------------------
// rotated_rect_segment_hit
// rotated rectangle against line segment strict crossing test
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and offers one
// hit bit per item on the output. The pipeline is an entry register and a
// 16-stage CORDIC for sine and cosine, then stages for the quadrant mapping,
// the corner products, the corners, the edge vectors, the cross products,
// the determinants and the final sign test. The whole pipeline advances
// whenever the output register is empty or being taken, so a stall at the
// output holds every stage in place.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_rect_segment_hit
  import rrsh_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // rect_length, rect_width, rect_angle, center_x, center_y,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, zero fill
  input  wire logic [((2*(COORD_BITS-1)+ANGLE_BITS+6*COORD_BITS)+7)/8*8-1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // hit, zero fill
  output logic [7:0] out_tdata
);

  localparam int W   = COORD_BITS;
  localparam int IW  = 2*(W-1) + ANGLE_BITS + 6*W;
  localparam int O_WID = W-1;
  localparam int O_ANG = 2*(W-1);
  localparam int O_CX  = O_ANG + ANGLE_BITS;
  localparam int O_CY  = O_CX + W;
  localparam int O_SX0 = O_CY + W;
  localparam int O_SY0 = O_SX0 + W;
  localparam int O_SX1 = O_SY0 + W;
  localparam int O_SY1 = O_SX1 + W;
  localparam int NC  = CORDIC_ITERS;
  localparam int XW  = CORDIC_XW;
  localparam int ZW  = CORDIC_ZW;
  localparam int PRW = W + 17;
  localparam int OW  = PRW + 1;
  localparam int PXW = W + 2;
  localparam int PW  = W + 3;
  localparam int MW  = 2*PW;
  localparam int DW  = MW + 1;
  localparam int EW  = DW + 1;
  localparam int NST = NC + 7;

  logic adv;
  logic [NST-1:0] vld_r;
  logic out_valid_r, out_hit_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_hit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NST-2:0], in_tvalid};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // cordic stages
  logic        [IW-1:0] fld_r [0:NC];
  quad_t                q_r   [0:NC];
  logic signed [XW-1:0] x_r   [0:NC];
  logic signed [XW-1:0] y_r   [0:NC];
  logic signed [ZW-1:0] z_r   [0:NC];
  logic [31:0] ang_nxt;

  assign ang_nxt = {in_tdata[O_ANG +: ANGLE_BITS], (32-ANGLE_BITS)'(0)};

  always_ff @(posedge clk) begin
    if (adv) begin
      fld_r[0] <= in_tdata[IW-1:0];
      q_r[0]   <= ang_nxt[31:30];
      x_r[0]   <= CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= ZW'({1'b0, ang_nxt[29:0]});
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        fld_r[i+1] <= fld_r[i];
        q_r[i+1]   <= q_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - atan_turn(4'(i));
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + atan_turn(4'(i));
        end
      end
    end
  end

  // saturate and map quadrant
  logic signed [XW-1:0] cs_nxt, sn_nxt;
  logic signed [TRIG_W-1:0] c_sat, s_sat, co_nxt, si_nxt;
  logic signed [TRIG_W-1:0] co_s_r, si_s_r;
  logic [IW-1:0] fld_s_r;

  always_comb begin
    cs_nxt = x_r[NC];
    sn_nxt = y_r[NC];
    if (cs_nxt > TRIG_MAX) cs_nxt = TRIG_MAX;
    if (cs_nxt < TRIG_MIN) cs_nxt = TRIG_MIN;
    if (sn_nxt > TRIG_MAX) sn_nxt = TRIG_MAX;
    if (sn_nxt < TRIG_MIN) sn_nxt = TRIG_MIN;
    c_sat = TRIG_W'(cs_nxt);
    s_sat = TRIG_W'(sn_nxt);
    case (q_r[NC])
      QUAD_0: begin co_nxt = c_sat;  si_nxt = s_sat;  end
      QUAD_1: begin co_nxt = -s_sat; si_nxt = c_sat;  end
      QUAD_2: begin co_nxt = -c_sat; si_nxt = -s_sat; end
      QUAD_3: begin co_nxt = s_sat;  si_nxt = -c_sat; end
      default: begin co_nxt = c_sat; si_nxt = s_sat;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      co_s_r  <= co_nxt;
      si_s_r  <= si_nxt;
      fld_s_r <= fld_r[NC];
    end
  end

  // corner products
  logic signed [W:0] len_s, wid_s;
  logic signed [PRW-1:0] pcl_m_r, psw_m_r, psl_m_r, pcw_m_r;
  logic signed [W-1:0] cx_m_r, cy_m_r, sx0_m_r, sy0_m_r, sx1_m_r, sy1_m_r;

  assign len_s = $signed({1'b0, fld_s_r[W-2:0]});
  assign wid_s = $signed({1'b0, fld_s_r[O_WID +: W-1]});

  always_ff @(posedge clk) begin
    if (adv) begin
      pcl_m_r <= PRW'(co_s_r) * PRW'(len_s);
      psw_m_r <= PRW'(si_s_r) * PRW'(wid_s);
      psl_m_r <= PRW'(si_s_r) * PRW'(len_s);
      pcw_m_r <= PRW'(co_s_r) * PRW'(wid_s);
      cx_m_r  <= $signed(fld_s_r[O_CX  +: W]);
      cy_m_r  <= $signed(fld_s_r[O_CY  +: W]);
      sx0_m_r <= $signed(fld_s_r[O_SX0 +: W]);
      sy0_m_r <= $signed(fld_s_r[O_SY0 +: W]);
      sx1_m_r <= $signed(fld_s_r[O_SX1 +: W]);
      sy1_m_r <= $signed(fld_s_r[O_SY1 +: W]);
    end
  end

  // corners
  logic signed [OW-1:0]  ox_nxt [4];
  logic signed [OW-1:0]  oy_nxt [4];
  logic signed [PXW-1:0] px_nxt [4];
  logic signed [PXW-1:0] py_nxt [4];
  logic signed [PXW-1:0] px_k_r [4];
  logic signed [PXW-1:0] py_k_r [4];
  logic signed [W-1:0] sx0_k_r, sy0_k_r, sx1_k_r, sy1_k_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ox_nxt[k] = (LEN_NEG[k] ? -OW'(pcl_m_r) : OW'(pcl_m_r))
                - (WID_NEG[k] ? -OW'(psw_m_r) : OW'(psw_m_r)) + OW'(ROUND_BIAS);
      oy_nxt[k] = (LEN_NEG[k] ? -OW'(psl_m_r) : OW'(psl_m_r))
                + (WID_NEG[k] ? -OW'(pcw_m_r) : OW'(pcw_m_r)) + OW'(ROUND_BIAS);
      px_nxt[k] = PXW'(cx_m_r) + $signed(ox_nxt[k][OW-1:ROUND_SHIFT]);
      py_nxt[k] = PXW'(cy_m_r) + $signed(oy_nxt[k][OW-1:ROUND_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_k_r  <= px_nxt;
      py_k_r  <= py_nxt;
      sx0_k_r <= sx0_m_r;
      sy0_k_r <= sy0_m_r;
      sx1_k_r <= sx1_m_r;
      sy1_k_r <= sy1_m_r;
    end
  end

  // edge vectors
  logic signed [PW-1:0] a_nxt [4];
  logic signed [PW-1:0] c_nxt [4];
  logic signed [PW-1:0] lx_nxt [4];
  logic signed [PW-1:0] ly_nxt [4];
  logic signed [PW-1:0] a_e_r [4];
  logic signed [PW-1:0] c_e_r [4];
  logic signed [PW-1:0] lx_e_r [4];
  logic signed [PW-1:0] ly_e_r [4];
  logic signed [PW-1:0] b_e_r, d_e_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_nxt[k]  = PW'(px_k_r[2'(k+1)]) - PW'(px_k_r[k]);
      c_nxt[k]  = PW'(py_k_r[2'(k+1)]) - PW'(py_k_r[k]);
      lx_nxt[k] = PW'(sx0_k_r) - PW'(px_k_r[k]);
      ly_nxt[k] = PW'(sy0_k_r) - PW'(py_k_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_e_r  <= a_nxt;
      c_e_r  <= c_nxt;
      lx_e_r <= lx_nxt;
      ly_e_r <= ly_nxt;
      b_e_r  <= PW'(sx0_k_r) - PW'(sx1_k_r);
      d_e_r  <= PW'(sy0_k_r) - PW'(sy1_k_r);
    end
  end

  // cross products
  logic signed [MW-1:0] ad_p_r [4];
  logic signed [MW-1:0] bc_p_r [4];
  logic signed [MW-1:0] dl_p_r [4];
  logic signed [MW-1:0] bl_p_r [4];
  logic signed [MW-1:0] al_p_r [4];
  logic signed [MW-1:0] cl_p_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        ad_p_r[k] <= MW'(a_e_r[k]) * MW'(d_e_r);
        bc_p_r[k] <= MW'(b_e_r) * MW'(c_e_r[k]);
        dl_p_r[k] <= MW'(d_e_r) * MW'(lx_e_r[k]);
        bl_p_r[k] <= MW'(b_e_r) * MW'(ly_e_r[k]);
        al_p_r[k] <= MW'(a_e_r[k]) * MW'(ly_e_r[k]);
        cl_p_r[k] <= MW'(c_e_r[k]) * MW'(lx_e_r[k]);
      end
    end
  end

  // determinants and numerators
  logic signed [DW-1:0] det_d_r [4];
  logic signed [DW-1:0] n1_d_r  [4];
  logic signed [DW-1:0] n2_d_r  [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        det_d_r[k] <= DW'(ad_p_r[k]) - DW'(bc_p_r[k]);
        n1_d_r[k]  <= DW'(dl_p_r[k]) - DW'(bl_p_r[k]);
        n2_d_r[k]  <= DW'(al_p_r[k]) - DW'(cl_p_r[k]);
      end
    end
  end

  // strict inside test on each edge
  logic signed [EW-1:0] dm1_nxt [4];
  logic signed [EW-1:0] dm2_nxt [4];
  logic [3:0] edge_hit;
  logic in1, in2, dpos;

  always_comb begin
    edge_hit = '0;
    for (int k = 0; k < 4; k++) begin
      dm1_nxt[k] = EW'(det_d_r[k]) - EW'(n1_d_r[k]);
      dm2_nxt[k] = EW'(det_d_r[k]) - EW'(n2_d_r[k]);
      dpos = det_d_r[k] > 0;
      in1 = dpos ? (n1_d_r[k] > 0 && dm1_nxt[k] > 0) : (n1_d_r[k] < 0 && dm1_nxt[k] < 0);
      in2 = dpos ? (n2_d_r[k] > 0 && dm2_nxt[k] > 0) : (n2_d_r[k] < 0 && dm2_nxt[k] < 0);
      edge_hit[k] = (det_d_r[k] != 0) && in1 && in2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= |edge_hit;
    end
  end

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline stalled with empty output");
  a_last_stage_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[NST-1] |=> out_tvalid)
    else $error("item lost at output register");
  a_entry_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item not tracked");

endmodule

`default_nettype wire

>>> test/rotated_rect_segment_hit_tb.sv
// ----------------------------------------------------------------------------
// rotated_rect_segment_hit_tb
// self-checking bench for the rotated rectangle segment crossing test
// ----------------------------------------------------------------------------
// Drives directed rectangles and segments, then random poses with segments
// placed around the rectangle or raw noise, under bursty input and
// stalling output. A bit-exact predictor in the scoreboard gives the
// expected hit bit for each accepted item, and results are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class hit_scoreboard;
  bit   expected_hits[$];
  int   fails;

  static function longint cordic_step_angle(int i);
    longint t[16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861};
    return t[i];
  endfunction

  static function longint clamp_trig(longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  static function bit strictly_within(logic signed [127:0] n, logic signed [127:0] det);
    if (det > 0) return (n > 0) && (det - n > 0);
    return (n < 0) && (n - det > 0);
  endfunction

  static function bit edge_crosses(longint x1i, longint y1i, longint x1f, longint y1f,
                                   longint x2i, longint y2i, longint x2f, longint y2f);
    logic signed [127:0] a, b, c, d, lx, ly, det;
    a = 128'(x1f - x1i); b = 128'(x2i - x2f); c = 128'(y1f - y1i); d = 128'(y2i - y2f);
    lx = 128'(x2i - x1i); ly = 128'(y2i - y1i);
    det = a * d - b * c;
    if (det == 0) return 1'b0;
    return strictly_within(d * lx - b * ly, det) && strictly_within(a * ly - c * lx, det);
  endfunction

  static function bit compute_hit(logic [207:0] d);
    longint len, wid, cx, cy, sx0, sy0, sx1, sy1;
    longint x, y, z, xs, ys, c, s, co, si, lx, wy, ox, oy;
    longint px[4], py[4];
    int sgx[4] = '{1, 1, -1, -1};
    int sgy[4] = '{-1, 1, 1, -1};
    logic [31:0] a;
    bit h;
    len = longint'(d[22:0]);
    wid = longint'(d[45:23]);
    a   = {d[61:46], 16'd0};
    cx  = longint'($signed(d[85:62]));
    cy  = longint'($signed(d[109:86]));
    sx0 = longint'($signed(d[133:110]));
    sy0 = longint'($signed(d[157:134]));
    sx1 = longint'($signed(d[181:158]));
    sy1 = longint'($signed(d[205:182]));
    z = longint'(a[29:0]);
    x = 19898;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= cordic_step_angle(i);
      end else begin
        x += ys; y -= xs; z += cordic_step_angle(i);
      end
    end
    c = clamp_trig(x);
    s = clamp_trig(y);
    case (a[31:30])
      2'd0: begin co = c;  si = s;  end
      2'd1: begin co = -s; si = c;  end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
    for (int k = 0; k < 4; k++) begin
      lx = sgx[k] * len;
      wy = sgy[k] * wid;
      ox = co * lx - si * wy;
      oy = si * lx + co * wy;
      px[k] = cx + ((ox + 32768) >>> 16);
      py[k] = cy + ((oy + 32768) >>> 16);
    end
    h = 1'b0;
    for (int k = 0; k < 4; k++)
      if (edge_crosses(px[k], py[k], px[(k+1)&3], py[(k+1)&3], sx0, sy0, sx1, sy1)) h = 1'b1;
    return h;
  endfunction

  function void note_item(logic [207:0] d);
    expected_hits.push_back(compute_hit(d));
  endfunction

  function void check_result(logic [7:0] d);
    bit e;
    if (expected_hits.size() == 0) begin
      $display("%0t: unexpected result, actual %b", $time, d);
      fails++;
      return;
    end
    e = expected_hits.pop_front();
    if (d !== {7'd0, e}) begin
      $display("%0t: hit mismatch, expected %b actual %b", $time, {7'd0, e}, d);
      fails++;
    end
  endfunction

  function int pending();
    return expected_hits.size();
  endfunction
endclass

module rotated_rect_segment_hit_tb;
  import rrsh_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [7:0]   out_tdata;

  hit_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_go = 0;
  bit  stim_done = 0;

  rotated_rect_segment_hit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [207:0] pack_query(int unsigned len, int unsigned wid,
      int unsigned ang, int cx, int cy, int sx0, int sy0, int sx1, int sy1);
    logic [207:0] d;
    d = '0;
    d[22:0] = len[22:0];   d[45:23] = wid[22:0];  d[61:46] = ang[15:0];
    d[85:62] = cx[23:0];   d[109:86] = cy[23:0];
    d[133:110] = sx0[23:0]; d[157:134] = sy0[23:0];
    d[181:158] = sx1[23:0]; d[205:182] = sy1[23:0];
    return d;
  endfunction

  // random pose with a segment around the rectangle, or raw noise
  function automatic logic [207:0] random_query();
    int unsigned len, wid, sc;
    int cx, cy, r;
    logic [207:0] d;
    if ($urandom_range(9) == 0) begin
      d = 208'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      d[207:206] = 2'b00;
      return d;
    end
    sc  = $urandom_range(20, 4);
    len = $urandom_range((1 << sc) - 1);
    wid = ($urandom_range(7) == 0) ? 0 : $urandom_range((1 << sc) - 1);
    if ($urandom_range(15) == 0) len = 0;
    r  = int'(len + wid) + 2;
    cx = int'($urandom_range(1 << 22)) - (1 << 21);
    cy = int'($urandom_range(1 << 22)) - (1 << 21);
    return pack_query(len, wid, $urandom_range(65535), cx, cy,
      cx + int'($urandom_range(2*r)) - r, cy + int'($urandom_range(2*r)) - r,
      cx + int'($urandom_range(2*r)) - r, cy + int'($urandom_range(2*r)) - r);
  endfunction

  task automatic offer(logic [207:0] d);
    in_tvalid <= 1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(d);
  endtask

  task automatic pause_input(int n);
    in_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // receiver: stall style is redrawn at random, with a long hold on request
  initial begin
    int hold, cyc, style;
    hold = 0;
    cyc = 0;
    style = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 100 == 0) style = $urandom_range(2);
      if (hold_go) begin
        hold = 300;
        hold_go = 0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else if (style == 0) out_tready <= 1;
      else if (style == 1) out_tready <= $urandom_range(1);
      else out_tready <= ($urandom_range(3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int burst;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // axis aligned box, crossing, touching and collinear segments
    offer(pack_query(2560, 1024, 0, 0, 0, -5000, 0, 5000, 0));
    offer(pack_query(2560, 1024, 0, 0, 0, 0, 0, 1280, 0));
    offer(pack_query(2560, 1024, 0, 0, 0, 0, 0, 1281, 0));
    offer(pack_query(2560, 1024, 0, 0, 0, -3000, 512, 3000, 512));
    offer(pack_query(2560, 1024, 0, 0, 0, -3000, 511, 3000, 511));
    offer(pack_query(2560, 1024, 0, 0, 0, 10, 10, 20, 20));
    offer(pack_query(2560, 1024, 0, 0, 0, 100, 100, 100, 100));
    // quadrant boundaries and top angle
    offer(pack_query(2560, 1024, 16384, 0, 0, -5000, 0, 5000, 0));
    offer(pack_query(2560, 1024, 32768, 100, -100, -5000, 3, 5000, 7));
    offer(pack_query(2560, 1024, 49152, 0, 0, 0, -5000, 0, 5000));
    offer(pack_query(2560, 1024, 65535, 0, 0, -5000, 1, 5000, -1));
    offer(pack_query(2560, 1024, 8192, 0, 0, -5000, 0, 5000, 0));
    // degenerate rectangles
    offer(pack_query(0, 1024, 0, 0, 0, -5000, 0, 5000, 0));
    offer(pack_query(2560, 0, 0, 0, 0, 0, -5000, 0, 5000));
    offer(pack_query(0, 0, 12345, 0, 0, -5000, 0, 5000, 0));
    // field extremes
    offer(pack_query(8388607, 8388607, 65535, 8388607, 8388607,
                     -8388608, -8388608, 8388607, 8388607));
    offer(pack_query(8388607, 8388607, 0, -8388608, -8388608,
                     8388607, -8388608, -8388608, 8388607));
    offer(pack_query(8388607, 0, 40000, 0, 0, -8388608, 8388607, 8388607, -8388608));
    offer(pack_query(0, 8388607, 20000, -8388608, 8388607, 0, 0, -1, -1));
    offer(pack_query(0, 0, 0, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < 650; ) begin
      burst = $urandom_range(40, 1);
      for (int j = 0; j < burst; j++) begin
        offer(random_query());
        i++;
      end
      if (i > 150 && i <= 150 + burst) hold_go = 1;
      if (i > 400 && i <= 400 + burst) begin
        in_tvalid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
      end else if ($urandom_range(2) != 0) pause_input($urandom_range(12, 1));
    end
    in_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
